// ===== design/ssp_pkg.sv =====
package ssp_pkg;

    localparam int ID_COUNT = 1024;
    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;

    localparam int ID_W     = $clog2(ID_COUNT);
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VER_W    = 10;
    localparam int TYPE_W   = 8;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 3;
    localparam int ENT_W    = ID_W + VER_W + TYPE_W;
    localparam int MAP_W    = 1 + SLOT_W;

    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SLOT   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STAT_W-1:0] ST_SLOT_RANGE = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [VER_W-1:0]  version;
        logic [TYPE_W-1:0] etype;
    } entity_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } map_entry_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              present;
        logic [SLOT_W-1:0] dense_index;
        logic [ID_W-1:0]   id_out;
        logic [VER_W-1:0]  version_out;
        logic [TYPE_W-1:0] type_out;
        logic [DATA_W-1:0] data_out;
        logic [CNT_W-1:0]  count;
    } result_t;

endpackage

// ===== design/ssp_ram.sv =====
module ssp_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/sparse_set_with_payload.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  action, entity id/version/type, slot index, data
// m_        out        m_valid / m_ready  status, present, slot, entity, data, count
//
// s_ready returns after S_MAP, S_ENT and S_DONE, with S_INVAL between for a held-id remove;
// the sparse map read, then the dense read at the mapped slot, then the write-back,
// set these states. A held-id remove writes the sparse map twice via its one write port.
// After reset the sparse map is swept clear, one entry a cycle, across all 1024 entries.
// A result waiting on m_ready holds the block before its next item completes.
module sparse_set_with_payload (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [9:0]  s_entity_id,
    input  logic [9:0]  s_entity_version,
    input  logic [7:0]  s_entity_type,
    input  logic [9:0]  s_slot_index,
    input  logic [31:0] s_data_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_present,
    output logic [9:0]  m_dense_index,
    output logic [9:0]  m_id_out,
    output logic [9:0]  m_version_out,
    output logic [7:0]  m_type_out,
    output logic [31:0] m_data_out,
    output logic [10:0] m_count
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MAP   = 6'b000100,
        S_ENT   = 6'b001000,
        S_INVAL = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ssp_pkg::ID_W-1:0]   clr_idx_reg;
    logic [ssp_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ssp_pkg::ACT_W-1:0]  act_reg;
    logic [ssp_pkg::ID_W-1:0]   id_reg;
    logic [ssp_pkg::VER_W-1:0]  ver_reg;
    logic [ssp_pkg::TYPE_W-1:0] type_reg;
    logic [ssp_pkg::SLOT_W-1:0] sidx_reg;
    logic [ssp_pkg::DATA_W-1:0] data_reg;
    logic                       held_reg;
    logic [ssp_pkg::SLOT_W-1:0] slot_reg;
    ssp_pkg::entity_t           tail_ent_reg;
    logic [ssp_pkg::DATA_W-1:0] tail_pay_reg;
    ssp_pkg::result_t           res_reg, res_next;
    ssp_pkg::result_t           out_reg;
    logic                       m_valid_reg;

    logic                       map_we;
    logic [ssp_pkg::ID_W-1:0]   map_waddr;
    ssp_pkg::map_entry_t        map_wdata;
    logic                       map_re;
    ssp_pkg::map_entry_t        map_rdata;

    logic                       ent_we;
    logic [ssp_pkg::SLOT_W-1:0] ent_waddr;
    ssp_pkg::entity_t           ent_wdata;
    logic                       pay_we;
    logic [ssp_pkg::SLOT_W-1:0] pay_waddr;
    logic [ssp_pkg::DATA_W-1:0] pay_wdata;
    logic                       dense_re;
    logic [ssp_pkg::SLOT_W-1:0] dense_raddr;
    ssp_pkg::entity_t           ent_rdata;
    logic [ssp_pkg::DATA_W-1:0] pay_rdata;

    logic                       s_fire;
    logic                       out_free;
    logic [ssp_pkg::CNT_W-1:0]  tail_cnt;
    logic                       map_held;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign tail_cnt = count_reg - ssp_pkg::CNT_W'(1);
    assign map_held = map_rdata.valid && ({1'b0, map_rdata.slot} < count_reg);

    ssp_ram #(
        .WIDTH (ssp_pkg::MAP_W),
        .DEPTH (ssp_pkg::ID_COUNT),
        .ADDR_W(ssp_pkg::ID_W)
    ) u_map_ram (
        .aclk (aclk),
        .we   (map_we),
        .waddr(map_waddr),
        .wdata(map_wdata),
        .re   (map_re),
        .raddr(s_entity_id),
        .rdata(map_rdata)
    );

    ssp_ram #(
        .WIDTH (ssp_pkg::ENT_W),
        .DEPTH (ssp_pkg::CAPACITY),
        .ADDR_W(ssp_pkg::SLOT_W)
    ) u_ent_ram (
        .aclk (aclk),
        .we   (ent_we),
        .waddr(ent_waddr),
        .wdata(ent_wdata),
        .re   (dense_re),
        .raddr(dense_raddr),
        .rdata(ent_rdata)
    );

    ssp_ram #(
        .WIDTH (ssp_pkg::DATA_W),
        .DEPTH (ssp_pkg::CAPACITY),
        .ADDR_W(ssp_pkg::SLOT_W)
    ) u_pay_ram (
        .aclk (aclk),
        .we   (pay_we),
        .waddr(pay_waddr),
        .wdata(pay_wdata),
        .re   (dense_re),
        .raddr(dense_raddr),
        .rdata(pay_rdata)
    );

    always_comb begin
        map_re   = s_fire;
        dense_re = s_fire || (state_reg == S_MAP);
        if (state_reg == S_MAP) begin
            dense_raddr = map_rdata.slot;
        end else if (s_action == ssp_pkg::ACT_SLOT) begin
            dense_raddr = s_slot_index;
        end else begin
            dense_raddr = tail_cnt[ssp_pkg::SLOT_W-1:0];
        end
    end

    always_comb begin
        res_next          = '0;
        res_next.present  = held_reg;
        res_next.count    = count_reg;
        count_next        = count_reg;
        map_we            = 1'b0;
        map_waddr         = id_reg;
        map_wdata         = '0;
        ent_we            = 1'b0;
        ent_waddr         = slot_reg;
        ent_wdata         = tail_ent_reg;
        pay_we            = 1'b0;
        pay_waddr         = slot_reg;
        pay_wdata         = tail_pay_reg;

        if (act_reg <= ssp_pkg::ACT_WRITE) begin
            res_next.id_out = id_reg;
        end

        unique case (act_reg) inside
            ssp_pkg::ACT_INSERT: begin
                if (held_reg) begin
                    res_next.status      = ssp_pkg::ST_DUPLICATE;
                    res_next.dense_index = slot_reg;
                    res_next.id_out      = ent_rdata.id;
                    res_next.version_out = ent_rdata.version;
                    res_next.type_out    = ent_rdata.etype;
                end else if (count_reg >= ssp_pkg::CNT_W'(ssp_pkg::CAPACITY)) begin
                    res_next.status = ssp_pkg::ST_FULL;
                end else begin
                    res_next.dense_index = count_reg[ssp_pkg::SLOT_W-1:0];
                    res_next.version_out = ver_reg;
                    res_next.type_out    = type_reg;
                    count_next           = count_reg + ssp_pkg::CNT_W'(1);
                    map_we               = 1'b1;
                    map_wdata.valid      = 1'b1;
                    map_wdata.slot       = count_reg[ssp_pkg::SLOT_W-1:0];
                    ent_we               = 1'b1;
                    ent_waddr            = count_reg[ssp_pkg::SLOT_W-1:0];
                    ent_wdata.id         = id_reg;
                    ent_wdata.version    = ver_reg;
                    ent_wdata.etype      = type_reg;
                    pay_we               = 1'b1;
                    pay_waddr            = count_reg[ssp_pkg::SLOT_W-1:0];
                    pay_wdata            = data_reg;
                end
            end
            ssp_pkg::ACT_REMOVE: begin
                if (!held_reg) begin
                    res_next.status = ssp_pkg::ST_NOT_FOUND;
                end else begin
                    res_next.dense_index = slot_reg;
                    res_next.id_out      = ent_rdata.id;
                    res_next.version_out = ent_rdata.version;
                    res_next.type_out    = ent_rdata.etype;
                    count_next           = tail_cnt;
                    map_we               = 1'b1;
                    map_waddr            = tail_ent_reg.id;
                    map_wdata.valid      = 1'b1;
                    map_wdata.slot       = slot_reg;
                    ent_we               = 1'b1;
                    pay_we               = 1'b1;
                end
            end
            ssp_pkg::ACT_READ, ssp_pkg::ACT_WRITE: begin
                if (!held_reg) begin
                    res_next.status = ssp_pkg::ST_NOT_FOUND;
                end else begin
                    res_next.dense_index = slot_reg;
                    res_next.id_out      = ent_rdata.id;
                    res_next.version_out = ent_rdata.version;
                    res_next.type_out    = ent_rdata.etype;
                    if (act_reg == ssp_pkg::ACT_WRITE) begin
                        pay_we    = 1'b1;
                        pay_wdata = data_reg;
                    end else begin
                        res_next.data_out = pay_rdata;
                    end
                end
            end
            ssp_pkg::ACT_SLOT: begin
                res_next.present = 1'b0;
                if ({1'b0, sidx_reg} >= count_reg) begin
                    res_next.status = ssp_pkg::ST_SLOT_RANGE;
                end else begin
                    res_next.present     = 1'b1;
                    res_next.dense_index = sidx_reg;
                    res_next.id_out      = tail_ent_reg.id;
                    res_next.version_out = tail_ent_reg.version;
                    res_next.type_out    = tail_ent_reg.etype;
                    res_next.data_out    = tail_pay_reg;
                end
            end
            default: begin
            end
        endcase
        res_next.count = count_next;

        if (state_reg != S_ENT) begin
            map_we = 1'b0;
            ent_we = 1'b0;
            pay_we = 1'b0;
        end
        if (state_reg == S_CLEAR) begin
            map_we    = 1'b1;
            map_waddr = clr_idx_reg;
            map_wdata = '0;
        end else if (state_reg == S_INVAL) begin
            map_we         = 1'b1;
            map_waddr      = id_reg;
            map_wdata.valid = 1'b0;
            map_wdata.slot  = slot_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_idx_reg == ssp_pkg::ID_W'(ssp_pkg::ID_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_MAP;
                end
            end
            S_MAP: begin
                state_next = S_ENT;
            end
            S_ENT: begin
                if (act_reg == ssp_pkg::ACT_REMOVE && held_reg) begin
                    state_next = S_INVAL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_INVAL: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + ssp_pkg::ID_W'(1);
            end
            if (state_reg == S_ENT) begin
                count_reg <= count_next;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg  <= s_action;
            id_reg   <= s_entity_id;
            ver_reg  <= s_entity_version;
            type_reg <= s_entity_type;
            sidx_reg <= s_slot_index;
            data_reg <= s_data_in;
        end
        if (state_reg == S_MAP) begin
            held_reg     <= map_held;
            slot_reg     <= map_rdata.slot;
            tail_ent_reg <= ent_rdata;
            tail_pay_reg <= pay_rdata;
        end
        if (state_reg == S_ENT) begin
            res_reg <= res_next;
        end
        if (state_reg == S_DONE && out_free) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_present     = out_reg.present;
    assign m_dense_index = out_reg.dense_index;
    assign m_id_out      = out_reg.id_out;
    assign m_version_out = out_reg.version_out;
    assign m_type_out    = out_reg.type_out;
    assign m_data_out    = out_reg.data_out;
    assign m_count       = out_reg.count;

endmodule

// ===== design/ssp_checker.sv =====
module ssp_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic        m_present,
    input logic [31:0] m_data_out,
    input logic [10:0] m_count
);

    // hold a stalled transfer
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_count))
        else $error("result changed while stalled");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count <= 11'(ssp_pkg::CAPACITY))
        else $error("count above capacity");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ssp_pkg::ST_FULL |-> m_count == 11'(ssp_pkg::CAPACITY))
        else $error("full reported below capacity");

    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ssp_pkg::ST_NOT_FOUND |-> !m_present && m_data_out == '0)
        else $error("not found with entity data");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ssp_pkg::ST_SLOT_RANGE |-> !m_present && m_data_out == '0)
        else $error("slot out of range with entity data");

endmodule

bind sparse_set_with_payload ssp_props u_ssp_props (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_status  (m_status),
    .m_present (m_present),
    .m_data_out(m_data_out),
    .m_count   (m_count)
);
